[rtl/core/gateway_table_least_loaded_select_core_defines.svh]
// -----------------------------------------------------------------------------
// Gateway table assertion macros
// Shared assertion macros for the gateway table core. Defining NO_ASSERTIONS
// turns every macro into an empty body.
// -----------------------------------------------------------------------------
`ifndef GATEWAY_TABLE_LEAST_LOADED_SELECT_CORE_DEFINES_SVH
`define GATEWAY_TABLE_LEAST_LOADED_SELECT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define GWTBL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gateway table: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define GWTBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gateway table: next-cycle check failed");
`else
`define GWTBL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GWTBL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/gwtbl_pkg.sv]
// -----------------------------------------------------------------------------
// Gateway table package
// Codes, widths and the stored entry layout shared by the gateway table core.
// -----------------------------------------------------------------------------
`default_nettype none

package gwtbl_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int USERS_W = 24;
	localparam int FREE_W  = USERS_W + 1;
	localparam int SUM_W   = IP_W + 1;

	typedef enum logic [1:0] {
		ACT_UPSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_ROUTE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NO_GW     = 2'd3
	} status_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [USERS_W-1:0] max_users;
		logic [USERS_W-1:0] cur_users;
		logic [PORT_W-1:0]  port;
		logic [IP_W-1:0]    ip;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/core/gateway_table_least_loaded_select_core.sv]
// -----------------------------------------------------------------------------
// Gateway table with least-loaded selection
// Keeps a table of gateways and answers upsert, delete and route requests.
// -----------------------------------------------------------------------------
// Usage:
// Requests arrive as beats on the s_ channel; each request produces exactly one
// result beat on the m_ channel. A request is an upsert (add a gateway or
// update its user counts), a delete, or a route request, which returns the old
// route when the sticky policy allows it and that gateway has room, and the
// gateway with the most free slots otherwise.
// Every request scans the whole table once through a single read port of the
// entry memory, one entry per cycle, feeding one shared compare unit. The
// result beat appears once the scan has drained and the output register is
// free, and s_tready rises in that same cycle; no new request is accepted
// before then, so the scan length sets how soon the next request can follow.
// The result sits in an output register: a new request is accepted while an
// earlier result waits, but the next result is held back until the receiver
// takes the pending one.
// After reset the table is empty and the sticky policy is on. No clearing pass
// is needed, as entries are tracked by valid bits in flip-flops.
// sticky_we/sticky_wdata write the sticky policy and may be used only while
// no request is outstanding.
// -----------------------------------------------------------------------------
`default_nettype none

`include "gateway_table_least_loaded_select_core_defines.svh"

module gateway_table_least_loaded_select_core #(
	parameter int TABLE_DEPTH = gwtbl_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        sticky_we,
	input  wire logic        sticky_wdata,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	// gw_ip [31:0], gw_port [47:32], cur_users [71:48], max_users [95:72]
	input  wire logic [95:0] s_tdata,
	// action [1:0], has_old_route [2]
	input  wire logic [2:0]  s_tuser,

	output logic             m_tvalid,
	input  wire logic        m_tready,
	// chosen_ip [31:0], chosen_port [47:32]
	output logic [47:0]      m_tdata,
	// status [1:0], used_old_route [2]
	output logic [2:0]       m_tuser
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IP_W = gwtbl_pkg::IP_W;
	localparam int PORT_W = gwtbl_pkg::PORT_W;
	localparam int FREE_W = gwtbl_pkg::FREE_W;
	localparam int SUM_W = gwtbl_pkg::SUM_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	// Request held for the whole scan.
	gwtbl_pkg::action_t item_action_q;
	gwtbl_pkg::entry_t  item_q;
	logic               item_old_q;
	logic               sticky_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [AW-1:0]          cnt_q;

	// Scan pipeline: s1 is the memory read, s2 holds the free count and sum.
	logic                      s1_v;
	logic [AW-1:0]             s1_idx;
	logic                      s2_v;
	logic                      s2_live;
	logic signed [FREE_W-1:0]  s2_free;
	logic [SUM_W-1:0]          s2_sum;
	logic [IP_W-1:0]           s2_ip;
	logic [PORT_W-1:0]         s2_port;

	// Scan results.
	logic                      match_found_q;
	logic                      match_open_q;
	logic [AW-1:0]             match_slot_q;
	logic                      free_found_q;
	logic [AW-1:0]             free_slot_q;
	logic                      best_found_q;
	logic signed [FREE_W-1:0]  best_free_q;
	logic [SUM_W-1:0]          best_sum_q;
	logic [IP_W-1:0]           best_ip_q;
	logic [PORT_W-1:0]         best_port_q;

	logic [gwtbl_pkg::ENTRY_W-1:0] ram_rdata;
	gwtbl_pkg::entry_t             rd_ent;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;

	logic                      in_acc;
	logic                      fin;
	logic                      rd_live;
	logic                      rd_hit;
	logic                      take_best;
	logic                      use_old;

	gwtbl_pkg::status_t        res_status;
	logic [IP_W-1:0]           res_ip;
	logic [PORT_W-1:0]         res_port;
	logic                      res_used;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign fin      = (state_q == S_FINISH) && (!m_tvalid || m_tready);
	assign use_old  = sticky_q && item_old_q;

	assign rd_ent  = gwtbl_pkg::entry_t'(ram_rdata);
	assign rd_live = valid_q[s1_idx];
	assign rd_hit  = rd_live && (rd_ent.ip == item_q.ip) && (rd_ent.port == item_q.port);

	// The shared compare: does the entry in s2 beat the best one so far?
	assign take_best = s2_v && s2_live &&
		(!best_found_q || (s2_free > best_free_q) ||
		 ((s2_free == best_free_q) && (s2_sum < best_sum_q)));

	// Outcome of the request once the scan is complete.
	always_comb begin
		res_status = gwtbl_pkg::STAT_OK;
		res_ip     = '0;
		res_port   = '0;
		res_used   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = match_slot_q;
		case (item_action_q)
			gwtbl_pkg::ACT_UPSERT: begin
				if (match_found_q) begin
					ram_we = fin;
				end else if (free_found_q) begin
					ram_we    = fin;
					ram_waddr = free_slot_q;
				end else begin
					res_status = gwtbl_pkg::STAT_FULL;
				end
			end
			gwtbl_pkg::ACT_DELETE: begin
				if (!match_found_q) begin
					res_status = gwtbl_pkg::STAT_NOT_FOUND;
				end
			end
			gwtbl_pkg::ACT_ROUTE: begin
				if (use_old && match_found_q && match_open_q) begin
					res_ip   = item_q.ip;
					res_port = item_q.port;
					res_used = 1'b1;
				end else if (best_found_q) begin
					res_ip   = best_ip_q;
					res_port = best_port_q;
				end else begin
					res_status = gwtbl_pkg::STAT_NO_GW;
				end
			end
			default: begin
				res_status = gwtbl_pkg::STAT_OK;
			end
		endcase
	end

	gwtbl_ram #(
		.WIDTH (gwtbl_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_q),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// Control: sequencer, valid bits, scan flags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sticky_q      <= 1'b1;
			valid_q       <= '0;
			cnt_q         <= '0;
			s1_v          <= 1'b0;
			s1_idx        <= '0;
			s2_v          <= 1'b0;
			match_found_q <= 1'b0;
			match_open_q  <= 1'b0;
			match_slot_q  <= '0;
			free_found_q  <= 1'b0;
			free_slot_q   <= '0;
			best_found_q  <= 1'b0;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
			m_tuser       <= '0;
		end else begin
			if (sticky_we) begin
				sticky_q <= sticky_wdata;
			end
			// A beat taken in the same cycle as a new result is replaced below.
			if (m_tvalid && m_tready && !fin) begin
				m_tvalid <= 1'b0;
			end

			s1_v   <= (state_q == S_SCAN);
			s1_idx <= cnt_q;
			s2_v   <= s1_v;

			if (s1_v) begin
				if (rd_hit && !match_found_q) begin
					match_found_q <= 1'b1;
					match_slot_q  <= s1_idx;
					match_open_q  <= (rd_ent.cur_users < rd_ent.max_users);
				end
				if (!rd_live && !free_found_q) begin
					free_found_q <= 1'b1;
					free_slot_q  <= s1_idx;
				end
			end
			if (take_best) begin
				best_found_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q       <= S_SCAN;
						cnt_q         <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						best_found_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (cnt_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!s1_v && !s2_v) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin) begin
						state_q  <= S_IDLE;
						m_tvalid <= 1'b1;
						m_tdata  <= {res_port, res_ip};
						m_tuser  <= {res_used, res_status};
						if (item_action_q == gwtbl_pkg::ACT_UPSERT && ram_we) begin
							valid_q[ram_waddr] <= 1'b1;
						end
						if (item_action_q == gwtbl_pkg::ACT_DELETE && match_found_q) begin
							valid_q[match_slot_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_action_q       <= gwtbl_pkg::action_t'(s_tuser[1:0]);
			item_old_q          <= s_tuser[2];
			item_q              <= gwtbl_pkg::entry_t'(s_tdata);
		end
		s2_live <= rd_live;
		s2_free <= $signed({1'b0, rd_ent.max_users}) - $signed({1'b0, rd_ent.cur_users});
		s2_sum  <= {1'b0, rd_ent.ip} + SUM_W'(rd_ent.port);
		s2_ip   <= rd_ent.ip;
		s2_port <= rd_ent.port;
		if (take_best) begin
			best_free_q <= s2_free;
			best_sum_q  <= s2_sum;
			best_ip_q   <= s2_ip;
			best_port_q <= s2_port;
		end
	end

	// A failed request never names a gateway.
	`GWTBL_ASSERT_IMPLIES(a_err_no_gw, clk, arst_n,
		m_tvalid && (m_tuser[1:0] != gwtbl_pkg::STAT_OK), m_tdata == '0)
	// The old route is granted only on a successful route.
	`GWTBL_ASSERT_IMPLIES(a_old_ok, clk, arst_n,
		m_tvalid && m_tuser[2], m_tuser[1:0] == gwtbl_pkg::STAT_OK)
	// Once a request is taken the block is busy for the scan.
	`GWTBL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_tready)
	// A new result is loaded only into a free or draining output register.
	`GWTBL_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, fin && m_tvalid, m_tready)

endmodule

`default_nettype wire

[rtl/core/gwtbl_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module gwtbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
